// ===== design/apq_pkg.sv =====
// ----------------------------------------------------------------------------
// apq_pkg
// Types and codes shared by the ascending priority queue and its cells.
// ----------------------------------------------------------------------------
package apq_pkg;

	localparam logic KIND_INSERT = 1'b0;
	localparam logic KIND_REMOVE = 1'b1;

	localparam logic [1:0] ST_DONE  = 2'd0;
	localparam logic [1:0] ST_FULL  = 2'd1;
	localparam logic [1:0] ST_EMPTY = 2'd2;

	typedef struct packed {
		logic               kind;
		logic signed [31:0] element;
		logic        [15:0] priority_req;
	} cmd_t;

	typedef struct packed {
		logic        [1:0]  status;
		logic signed [31:0] removed_element;
		logic        [15:0] removed_priority;
		logic        [7:0]  occupancy;
	} rsp_t;

	typedef struct packed {
		logic signed [31:0] elem;
		logic        [15:0] prio;
	} entry_t;

	// broadcast to every cell in the chain
	typedef struct packed {
		logic               ins;
		logic               rem;
		logic signed [31:0] elem;
		logic        [15:0] prio;
	} op_t;

endpackage

// ===== design/apq_cell.sv =====
// ----------------------------------------------------------------------------
// apq_cell
// One slot of the sorted queue: holds an entry, takes the new entry or its
// left neighbor on insert, its right neighbor on remove.
// ----------------------------------------------------------------------------
module apq_cell import apq_pkg::*; #(
	parameter int IDX = 0,
	parameter int CW  = 8
) (
	input  logic          clk,
	input  op_t           op,
	input  logic [CW-1:0] count,
	input  entry_t        left,
	input  logic          left_ge,
	input  entry_t        right,
	output entry_t        entry,
	output logic          ge
);

	entry_t entry_q;
	logic   valid;

	assign valid = count > CW'(IDX);
	// slot at or behind the insert point: empty, or priority not below the new one
	assign ge    = !valid || (entry_q.prio >= op.prio);
	assign entry = entry_q;

	always_ff @(posedge clk) begin
		priority if (op.ins && ge) begin
			entry_q <= left_ge ? left : entry_t'{elem: op.elem, prio: op.prio};
		end else if (op.rem) begin
			entry_q <= right;
		end
	end

endmodule

// ===== design/ascending_priority_queue.sv =====
// ----------------------------------------------------------------------------
// ascending_priority_queue
// Bounded priority queue kept sorted in a chain of cells, smallest priority
// at the front; insert goes ahead of ties, remove takes the front entry.
// ----------------------------------------------------------------------------
//  channel   ports              transaction
//  command   start, busy, req   start high and busy low at a clock edge
//  result    done, rsp          done high for one cycle, taken at its end
//
//  One command per cycle: every cell compares and shifts in parallel, so the
//  queue state is final at the accepting edge and the result shows on the
//  next cycle. busy stays low. Reset empties the queue (count only); the
//  result side cannot stall, so no result is ever held back.
// ----------------------------------------------------------------------------
module ascending_priority_queue import apq_pkg::*; #(
	parameter int CAPACITY = 128
) (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	output logic busy,
	input  cmd_t req,
	output logic done,
	output rsp_t rsp
);

	localparam int CW = $clog2(CAPACITY + 1);

	logic [CW-1:0] count_q;
	logic [CW-1:0] count_next;
	logic          accept;
	logic          full;
	logic          empty;
	op_t           op;
	entry_t        entries [CAPACITY];
	logic          ges     [CAPACITY];
	logic          done_q;
	rsp_t          rsp_q;
	rsp_t          rsp_next;

	assign busy   = 1'b0;
	assign accept = start && !busy;
	assign full   = count_q == CW'(CAPACITY);
	assign empty  = count_q == '0;

	assign op.ins  = accept && (req.kind == KIND_INSERT) && !full;
	assign op.rem  = accept && (req.kind == KIND_REMOVE) && !empty;
	assign op.elem = req.element;
	assign op.prio = req.priority_req;

	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		entry_t left_e;
		entry_t right_e;
		logic   left_g;
		if (i == 0) begin : g_first
			assign left_e = '0;
			assign left_g = 1'b0;
		end else begin : g_mid
			assign left_e = entries[i-1];
			assign left_g = ges[i-1];
		end
		if (i == CAPACITY - 1) begin : g_last
			assign right_e = '0;
		end else begin : g_inner
			assign right_e = entries[i+1];
		end
		apq_cell #(.IDX(i), .CW(CW)) u_cell (
			.clk     (clk),
			.op      (op),
			.count   (count_q),
			.left    (left_e),
			.left_ge (left_g),
			.right   (right_e),
			.entry   (entries[i]),
			.ge      (ges[i])
		);
	end

	always_comb begin
		count_next = count_q;
		if (op.ins) begin
			count_next = count_q + CW'(1);
		end else if (op.rem) begin
			count_next = count_q - CW'(1);
		end
	end

	always_comb begin
		rsp_next                  = '0;
		rsp_next.status           = ST_DONE;
		if (req.kind == KIND_INSERT) begin
			if (full) begin
				rsp_next.status = ST_FULL;
			end
		end else if (empty) begin
			rsp_next.status = ST_EMPTY;
		end else begin
			rsp_next.removed_element  = entries[0].elem;
			rsp_next.removed_priority = entries[0].prio;
		end
		// saturate occupancy for deep queues
		if (32'(count_next) > 32'd255) begin
			rsp_next.occupancy = 8'hFF;
		end else begin
			rsp_next.occupancy = 8'(count_next);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			done_q  <= 1'b0;
		end else begin
			count_q <= count_next;
			done_q  <= accept;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			rsp_q <= rsp_next;
		end
	end

	assign done = done_q;
	assign rsp  = rsp_q;

`ifndef SYNTHESIS
	a_done_follows_accept: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(accept))
		else $error("result without an accepted command");

	a_count_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(CAPACITY))
		else $error("entry count above capacity");

	a_empty_result_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(done && rsp.status == ST_EMPTY) |->
		(rsp.occupancy == 8'd0 && rsp.removed_element == 32'sd0 &&
		 rsp.removed_priority == 16'd0))
		else $error("empty status with data or nonzero occupancy");

	a_front_sorted: assert property (@(posedge clk) disable iff (!arst_n)
		(count_q >= CW'(2)) |-> (entries[0].prio <= entries[1].prio))
		else $error("front entries out of order");

	a_remove_decrements: assert property (@(posedge clk) disable iff (!arst_n)
		op.rem |=> (count_q == $past(count_q) - CW'(1)))
		else $error("remove did not shrink the queue");
`endif

endmodule

// ===== test/tb_ascending_priority_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_ascending_priority_queue
// Drives insert and remove commands into the sorted queue with random
// idle gaps. A shadow copy of the sorted entries predicts every response,
// and each response is checked field by field in order. The stimulus covers
// remove on empty, insert on full, ties, field extremes and long random runs.
// ----------------------------------------------------------------------------
module tb_ascending_priority_queue import apq_pkg::*;;

	localparam int CAP          = 128;
	localparam int LONG_GAP_MAX = 40;
	localparam int REPORT_MAX   = 40;

	logic clk    = 1'b0;
	logic arst_n = 1'b0;
	logic start  = 1'b0;
	cmd_t req    = '0;
	logic busy;
	logic done;
	rsp_t rsp;

	// shadow of the sorted queue contents
	entry_t shadow_entries [CAP];
	int     shadow_count = 0;
	rsp_t   rsp_due_q [$];
	int     fail_count = 0;
	bit     no_idle = 1'b0;

	ascending_priority_queue #(
		.CAPACITY(CAP)
	) dut (
		.clk   (clk),
		.arst_n(arst_n),
		.start (start),
		.busy  (busy),
		.req   (req),
		.done  (done),
		.rsp   (rsp)
	);

	always #4 clk = ~clk;

	// Apply one command to the shadow queue and return the response it causes.
	function automatic rsp_t queue_apply(cmd_t c);
		rsp_t r;
		int   pos;
		int   i;
		r = '0;
		r.status = ST_DONE;
		if (c.kind == KIND_INSERT) begin
			if (shadow_count >= CAP) begin
				r.status = ST_FULL;
			end else begin
				pos = 0;
				while (pos < shadow_count && shadow_entries[pos].prio < c.priority_req)
					pos++;
				for (i = shadow_count; i > pos; i--)
					shadow_entries[i] = shadow_entries[i - 1];
				shadow_entries[pos].elem = c.element;
				shadow_entries[pos].prio = c.priority_req;
				shadow_count++;
			end
		end else begin
			if (shadow_count == 0) begin
				r.status = ST_EMPTY;
			end else begin
				r.removed_element  = shadow_entries[0].elem;
				r.removed_priority = shadow_entries[0].prio;
				for (i = 1; i < shadow_count; i++)
					shadow_entries[i - 1] = shadow_entries[i];
				shadow_count--;
			end
		end
		r.occupancy = (shadow_count > 255) ? 8'd255 : 8'(shadow_count);
		return r;
	endfunction

	task automatic compare_field(string name, logic [31:0] want, logic [31:0] got);
		if (got !== want) begin
			fail_count++;
			if (fail_count <= REPORT_MAX)
				$display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
		end
	endtask

	// Check responses first, then record the transaction taken at this edge.
	always @(posedge clk) begin : rsp_check
		rsp_t due;
		if (arst_n) begin
			if (done) begin
				if (rsp_due_q.size() == 0) begin
					fail_count++;
					if (fail_count <= REPORT_MAX)
						$display("%0t: response with no transaction waiting, expected none, actual %p",
							$time, rsp);
				end else begin
					due = rsp_due_q.pop_front();
					compare_field("status", 32'(due.status), 32'(rsp.status));
					compare_field("removed_element", due.removed_element, rsp.removed_element);
					compare_field("removed_priority", 32'(due.removed_priority),
						32'(rsp.removed_priority));
					compare_field("occupancy", 32'(due.occupancy), 32'(rsp.occupancy));
				end
			end
			if (start && !busy)
				rsp_due_q.push_back(queue_apply(req));
		end
	end

	function automatic int rand_gap();
		int r;
		if (no_idle)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(8, LONG_GAP_MAX);
	endfunction

	function automatic logic [15:0] rand_prio(int prio_max);
		int r;
		r = $urandom_range(0, 9);
		if (r == 0)
			return 16'd0;
		if (r == 1 && prio_max == 65535)
			return 16'hFFFF;
		return 16'($urandom_range(0, prio_max));
	endfunction

	// Drop start for the requested idle gap and put noise on the command bus.
	task automatic idle(int n);
		logic [63:0] noise;
		if (n > 0) begin
			noise = {$urandom, $urandom};
			@(negedge clk);
			start <= 1'b0;
			req   <= noise[$bits(cmd_t)-1:0];
			repeat (n - 1) @(negedge clk);
		end
	endtask

	task automatic send_cmd(logic kind, logic signed [31:0] elem, logic [15:0] prio);
		cmd_t c;
		c.kind         = kind;
		c.element      = elem;
		c.priority_req = prio;
		@(negedge clk);
		start <= 1'b1;
		req   <= c;
		@(posedge clk);
		while (busy) @(posedge clk);
		idle(rand_gap());
	endtask

	task automatic test_empty_remove();
		send_cmd(KIND_REMOVE, -32'sd1, 16'hFFFF);
		send_cmd(KIND_REMOVE, 32'sh12345678, 16'h0000);
	endtask

	task automatic test_extremes_and_ties();
		send_cmd(KIND_INSERT, 32'sh7FFFFFFF, 16'hFFFF);
		send_cmd(KIND_INSERT, 32'sh80000000, 16'h0000);
		send_cmd(KIND_INSERT, 32'sd0, 16'd100);
		// ties: each new entry goes ahead of the older ones
		send_cmd(KIND_INSERT, 32'sd1, 16'd100);
		send_cmd(KIND_INSERT, -32'sd1, 16'd100);
		send_cmd(KIND_INSERT, 32'sh55555555, 16'hFFFF);
		send_cmd(KIND_INSERT, 32'shAAAAAAAA, 16'hAAAA);
		send_cmd(KIND_INSERT, 32'sh00000000, 16'h5555);
		repeat (9) send_cmd(KIND_REMOVE, $urandom, 16'($urandom));
	endtask

	task automatic test_fill_drain(int prio_max);
		repeat (CAP) send_cmd(KIND_INSERT, $urandom, rand_prio(prio_max));
		repeat (3) send_cmd(KIND_INSERT, $urandom, rand_prio(prio_max));
		repeat (CAP) send_cmd(KIND_REMOVE, $urandom, 16'($urandom));
		repeat (2) send_cmd(KIND_REMOVE, $urandom, 16'($urandom));
	endtask

	task automatic test_random_walk(int n, int insert_pct, int prio_max);
		int k;
		for (k = 0; k < n; k++) begin
			if (k % 50 == 0)
				no_idle = ($urandom_range(0, 4) == 0);
			if ($urandom_range(0, 99) < insert_pct)
				send_cmd(KIND_INSERT, $urandom, rand_prio(prio_max));
			else
				send_cmd(KIND_REMOVE, $urandom, 16'($urandom));
		end
		no_idle = 1'b0;
	endtask

	initial begin
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		test_empty_remove();
		test_extremes_and_ties();
		test_fill_drain(65535);
		test_fill_drain(3);
		test_random_walk(500, 65, 65535);
		test_random_walk(450, 35, 65535);
		test_random_walk(500, 50, 7);
		@(negedge clk);
		start <= 1'b0;
		while (rsp_due_q.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
		if (fail_count == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

	initial begin
		#5_000_000;
		$display("CHECK FAILED");
		$finish;
	end

endmodule
